[hw/rtl/wel_pkg.sv]
// Package for the windowed exponential low-pass block.
// Holds the payload structs, lane control struct, register indexes and fixed widths.
// No dependencies.
`default_nettype none

package wel_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = SAMPLE_W + FRAC_W;
    localparam int GAIN_W    = 17;
    localparam int WIN_W     = 5;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [GAIN_W-1:0]    GAIN_ONE   = 17'h10000;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_x;
        logic signed [SAMPLE_W-1:0] filtered_y;
        logic signed [SAMPLE_W-1:0] filtered_z;
    } t_out;

    // Per-step control shared by all lanes
    typedef struct packed {
        logic step;
        logic first;
    } t_lane_ctl;

endpackage

`default_nettype wire

[hw/rtl/wel_hist_mem.sv]
// Sample history memory: one row per history slot, all axes side by side.
// Synchronous write, registered read, per-row valid bits so a cleared row reads as zero.
// Depends on nothing beyond its parameters.
`default_nettype none

module wel_hist_mem #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row_valid <= '0;
        end else if (i_we) begin
            r_row_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else if (i_re) begin
            r_rvalid <= r_row_valid[i_raddr];
        end
    end

    // Rows never written since the last clear read as zero
    assign o_rdata = r_rvalid ? r_rdata : '0;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_we && i_re))
        else $error("history written and read in the same cycle");

    a_no_clear_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_clear && i_we))
        else $error("history cleared while a row is written");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_row_valid == '0))
        else $error("rows still valid after clear");

endmodule

`default_nettype wire

[hw/rtl/wel_lane.sv]
// One axis of the low-pass filter: running value with 16 fraction bits,
// one multiply-add step per history sample. Depends on wel_pkg.
`default_nettype none

module wel_lane (
    input  wire logic                                i_clk,
    input  wire wel_pkg::t_lane_ctl                  i_ctl,
    input  wire logic signed [wel_pkg::SAMPLE_W-1:0] i_x,
    input  wire logic        [wel_pkg::GAIN_W-1:0]   i_gain,
    output logic signed      [wel_pkg::SAMPLE_W-1:0] o_y
);
    import wel_pkg::*;

    logic signed [ACC_W-1:0]         r_acc;
    logic signed [ACC_W-1:0]         n_acc;
    logic signed [ACC_W:0]           x_q;
    logic signed [ACC_W:0]           diff;
    logic signed [GAIN_W:0]          gain_s;
    logic signed [ACC_W+GAIN_W+1:0]  prod;
    logic signed [ACC_W-1:0]         corr;

    always_comb begin
        x_q    = $signed({i_x[SAMPLE_W-1], i_x, {FRAC_W{1'b0}}});
        diff   = x_q - $signed({r_acc[ACC_W-1], r_acc});
        gain_s = $signed({1'b0, i_gain});
        prod   = gain_s * diff;
        // Floor by arithmetic shift; the sum stays in sample range so the low bits suffice
        corr   = prod[ACC_W+FRAC_W-1:FRAC_W];
        n_acc  = i_ctl.first ? x_q[ACC_W-1:0] : r_acc + corr;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_acc <= n_acc;
        end
    end

    assign o_y = r_acc[ACC_W-1:FRAC_W];

endmodule

`default_nettype wire

[hw/rtl/windowed_exponential_lowpass.sv]
// Top level of the windowed exponential low-pass filter.
// Instantiates wel_hist_mem and one wel_lane per axis; uses wel_pkg.
`default_nettype none

// Each transaction carries one sample per axis. The samples are written into a
// circular history of window_length rows, then the history is read back from
// oldest to newest, one row per cycle from a single-port-read memory, while all
// axes run y += gain*(x - y) side by side. After the edge that accepts the item,
// the block makes the window_length reads, the last filter step and the output
// load, in that order; the output load waits while a result still waits
// downstream. The next item can be accepted only after the output load, so the
// block takes no new item while one is in flight. Input ready is high whenever no
// item is in flight, even if a result still waits downstream. Writing
// window_length resets the history to zero at once through per-row valid bits;
// there is no clearing pass.
module windowed_exponential_lowpass #(
    parameter int AXES     = 3,
    parameter int HIST_MAX = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire wel_pkg::t_in                  i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output wel_pkg::t_out                      o_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [wel_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wel_pkg::CFG_W-1:0]     i_cfg_data
);
    import wel_pkg::*;

    localparam int PTR_W = (HIST_MAX > 1) ? $clog2(HIST_MAX) : 1;
    localparam int LEN_W = $clog2(HIST_MAX + 1);
    localparam int ROW_W = AXES * SAMPLE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_LAST = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [GAIN_W-1:0]  r_gain;
    logic [LEN_W-1:0]   r_len;
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_rd_act, r_rd_first;
    logic               r_out_valid;
    t_out               r_out;

    logic               accept;
    logic               win_write;
    logic               issue;
    logic               last_issue;
    logic               out_free;
    logic [ROW_W-1:0]   w_row;
    logic [ROW_W-1:0]   r_row;
    logic [WIN_W-1:0]   win_raw;
    logic [GAIN_W-1:0]  gain_raw;
    t_lane_ctl          lane_ctl;
    logic signed [SAMPLE_W-1:0] lane_y [AXES];

    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] p,
                                                input logic [LEN_W-1:0] len);
        if (LEN_W'(p) == len - 1'b1) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign accept     = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign issue      = (r_state == S_RUN);
    assign last_issue = issue && (r_cnt == r_len - 1'b1);
    assign out_free   = !r_out_valid || i_ready;
    assign win_write  = i_cfg_we && (i_cfg_idx == REG_WINDOW);
    assign win_raw    = i_cfg_data[WIN_W-1:0];
    assign gain_raw   = i_cfg_data[GAIN_W-1:0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
            r_len  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN: begin
                    r_gain <= (gain_raw > GAIN_ONE) ? GAIN_ONE : gain_raw;
                end
                REG_WINDOW: begin
                    if (win_raw == '0) begin
                        r_len <= LEN_W'(1);
                    end else if (32'(win_raw) > HIST_MAX) begin
                        r_len <= LEN_W'(HIST_MAX);
                    end else begin
                        r_len <= LEN_W'(win_raw);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer: write new row, then read the window oldest first
    always_comb begin
        n_state = r_state;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_wptr  = f_wrap(r_wptr, r_len);
                    n_rptr  = f_wrap(r_wptr, r_len);
                    n_cnt   = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_rptr = f_wrap(r_rptr, r_len);
                n_cnt  = r_cnt + 1'b1;
                if (last_issue) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (win_write) begin
            n_wptr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_cnt      <= '0;
            r_rd_act   <= 1'b0;
            r_rd_first <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wptr     <= n_wptr;
            r_rptr     <= n_rptr;
            r_cnt      <= n_cnt;
            r_rd_act   <= issue;
            r_rd_first <= issue && (r_cnt == '0);
        end
    end

    // Pack the new samples into one history row; axes past the third get zero
    for (genvar ga = 0; ga < AXES; ga++) begin : g_row
        if (ga == 0) begin : g_x
            assign w_row[ga*SAMPLE_W +: SAMPLE_W] = i_data.sample_x;
        end else if (ga == 1) begin : g_y
            assign w_row[ga*SAMPLE_W +: SAMPLE_W] = i_data.sample_y;
        end else if (ga == 2) begin : g_z
            assign w_row[ga*SAMPLE_W +: SAMPLE_W] = i_data.sample_z;
        end else begin : g_pad
            assign w_row[ga*SAMPLE_W +: SAMPLE_W] = '0;
        end
    end

    wel_hist_mem #(
        .WIDTH (ROW_W),
        .DEPTH (HIST_MAX),
        .AW    (PTR_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (win_write),
        .i_we    (accept),
        .i_waddr (r_wptr),
        .i_wdata (w_row),
        .i_re    (issue),
        .i_raddr (r_rptr),
        .o_rdata (r_row)
    );

    assign lane_ctl.step  = r_rd_act;
    assign lane_ctl.first = r_rd_first;

    for (genvar ga = 0; ga < AXES; ga++) begin : g_lane
        wel_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_x    ($signed(r_row[ga*SAMPLE_W +: SAMPLE_W])),
            .i_gain (r_gain),
            .o_y    (lane_y[ga])
        );
    end

    // Output register: hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && out_free) begin
            r_out.filtered_x <= (AXES > 0) ? lane_y[0] : '0;
            r_out.filtered_y <= (AXES > 1) ? lane_y[(AXES > 1) ? 1 : 0] : '0;
            r_out.filtered_z <= (AXES > 2) ? lane_y[(AXES > 2) ? 2 : 0] : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_wptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_wptr) < r_len)
        else $error("write pointer outside the window");

    a_read_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (LEN_W'(r_rptr) < r_len) && (r_cnt < r_len))
        else $error("history read outside the window");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RUN))
        else $error("accepted transaction did not start the read loop");

    a_last_ends_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_issue |=> !issue && r_rd_act)
        else $error("reads continued past the window");

endmodule

`default_nettype wire
